FILE: hw/rtl/rti_pkg.sv
package rti_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_T_MIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_T_MAX    = 3'd7;

    // Normal format: signed Q1.30 in 32 bits
    localparam int NORM_W    = 32;
    localparam int NORM_FRAC = 30;

    // Near-zero determinant threshold is 1 / NEAR_ZERO_DEN in real units
    localparam logic [31:0] NEAR_ZERO_DEN = 32'd100000000;

endpackage

FILE: hw/rtl/rti_div.sv
module rti_div #(
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 4,
    parameter int Q_W    = 4,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic              ovf,
    output logic [SIDE_W-1:0] side_out
);

    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic              vld_reg  [Q_W+1];
    logic [DEN_W-1:0]  rem_reg  [Q_W];
    logic [Q_W-1:0]    lo_reg   [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    quo_reg  [Q_W+1];
    logic              ovf_reg  [Q_W+1];
    logic [SIDE_W-1:0] side_reg [Q_W+1];

    logic [HI_W-1:0] hi;
    logic            ovf_next;

    assign hi       = num[NUM_W-1:Q_W];
    // quotient cannot fit when the upper part already reaches the divisor
    assign ovf_next = CMP_W'(hi) >= CMP_W'(den);

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            rem_reg[0]  <= DEN_W'(hi);
            lo_reg[0]   <= num[Q_W-1:0];
            den_reg[0]  <= den;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           take;

        assign trial = {rem_reg[k-1], lo_reg[k-1][Q_W-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};
        assign take  = trial >= {1'b0, den_reg[k-1]};

        always_ff @(posedge clk) begin
            if (!rst_n) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                quo_reg[k]  <= {quo_reg[k-1][Q_W-2:0], take};
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end

        if (k < Q_W) begin : g_carry
            always_ff @(posedge clk) begin
                if (en) begin
                    rem_reg[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    lo_reg[k]  <= {lo_reg[k-1][Q_W-2:0], 1'b0};
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign quo       = quo_reg[Q_W];
    assign ovf       = ovf_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

FILE: hw/rtl/rti_sqrt.sv
module rti_sqrt #(
    parameter int X_W    = 61,
    parameter int SIDE_W = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [X_W-1:0]         x,
    input  logic [SIDE_W-1:0]      side_in,
    output logic                   out_valid,
    output logic [(X_W+1)/2-1:0]   root,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int RB = (X_W + 1) / 2;
    localparam int TW = 2 * RB + 1;

    logic              vld_reg  [RB+1];
    logic [TW-1:0]     rad_reg  [RB];
    logic [RB-1:0]     root_reg [RB+1];
    logic [SIDE_W-1:0] side_reg [RB+1];

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            rad_reg[0]  <= TW'(x);
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    // One root bit a stage; the radicand holds x minus the square of the root so far
    for (genvar k = 1; k <= RB; k++) begin : g_stage
        localparam int B = RB - k;
        logic [TW-1:0] trial;
        logic          take;

        assign trial = (TW'(root_reg[k-1]) << (B + 1)) + (TW'(1) << (2 * B));
        assign take  = rad_reg[k-1] >= trial;

        always_ff @(posedge clk) begin
            if (!rst_n) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                root_reg[k] <= root_reg[k-1] | (take ? (RB'(1) << B) : RB'(0));
                side_reg[k] <= side_reg[k-1];
            end
        end

        if (k < RB) begin : g_carry
            always_ff @(posedge clk) begin
                if (en) begin
                    rad_reg[k] <= take ? (rad_reg[k-1] - trial) : rad_reg[k-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[RB];
    assign root      = root_reg[RB];
    assign side_out  = side_reg[RB];

endmodule

FILE: hw/rtl/ray_triangle_intersect.sv
// Throughput: one triangle per cycle; the whole pipeline advances when the output
// register is empty or being taken, and holds otherwise.
// The t quotient takes one stage per quotient bit, the normal quotient 61 and the
// square root 31, which set the depth. Reset clears valid bits and loads the ray registers with defaults.
module ray_triangle_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_WIDTH-1:0]             cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [COORD_WIDTH-1:0]      s_first_vertex_x,
    input  logic signed [COORD_WIDTH-1:0]      s_first_vertex_y,
    input  logic signed [COORD_WIDTH-1:0]      s_first_vertex_z,
    input  logic signed [COORD_WIDTH-1:0]      s_second_vertex_x,
    input  logic signed [COORD_WIDTH-1:0]      s_second_vertex_y,
    input  logic signed [COORD_WIDTH-1:0]      s_second_vertex_z,
    input  logic signed [COORD_WIDTH-1:0]      s_third_vertex_x,
    input  logic signed [COORD_WIDTH-1:0]      s_third_vertex_y,
    input  logic signed [COORD_WIDTH-1:0]      s_third_vertex_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic signed [COORD_WIDTH-1:0]      m_hit_distance,
    output logic signed [COORD_WIDTH-1:0]      m_hit_point_x,
    output logic signed [COORD_WIDTH-1:0]      m_hit_point_y,
    output logic signed [COORD_WIDTH-1:0]      m_hit_point_z,
    output logic signed [rti_pkg::NORM_W-1:0]  m_normal_x,
    output logic signed [rti_pkg::NORM_W-1:0]  m_normal_y,
    output logic signed [rti_pkg::NORM_W-1:0]  m_normal_z
);
    import rti_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int EW     = CW + 1;           // edges and origin offset
    localparam int PW     = 2 * EW;           // single cross-product terms
    localparam int XW     = 2 * EW + 1;       // cross products
    localparam int DW     = EW + XW + 2;      // dot products
    localparam int CSQ_W  = 2 * XW;           // squared normal components
    localparam int SS_W   = 2 * XW + 2;       // squared normal length
    localparam int NB_W   = 3 + SS_W + 3 * CSQ_W;
    localparam int TQ_W   = CW + 1;
    localparam int TS_W   = 3 + NB_W;
    localparam int NQ_W   = 2 * NORM_FRAC + 1;
    localparam int NN_W   = CSQ_W + 2 * NORM_FRAC;
    localparam int RB     = (NQ_W + 1) / 2;
    localparam int S0_W   = 4 * CW + 4;
    localparam int HW     = 2 * CW + 1;
    localparam int LO_W   = (XW + 1) / 2;     // unsigned lower half of a cross product
    localparam int HI_W   = XW - LO_W;        // signed upper half
    localparam int PL_W   = EW + LO_W + 1;
    localparam int PH_W   = EW + HI_W;
    localparam int QL_W   = 2 * LO_W;
    localparam int QM_W   = HI_W + LO_W + 1;
    localparam int QH_W   = 2 * HI_W;

    localparam logic [DW-1:0] DET_MIN =
        DW'(((128'd1 << (3 * FRAC_BITS)) + 128'(NEAR_ZERO_DEN) - 128'd1)
            / 128'(NEAR_ZERO_DEN));
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic en;

    // ray registers
    logic signed [CW-1:0] org_reg [3];
    logic signed [CW-1:0] dir_reg [3];
    logic signed [CW-1:0] tmin_reg;
    logic signed [CW-1:0] tmax_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= CW'(1) << FRAC_BITS;
            tmin_reg   <= '0;
            tmax_reg   <= C_MAX;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORIGIN_X: org_reg[0] <= cfg_data;
                REG_ORIGIN_Y: org_reg[1] <= cfg_data;
                REG_ORIGIN_Z: org_reg[2] <= cfg_data;
                REG_DIR_X:    dir_reg[0] <= cfg_data;
                REG_DIR_Y:    dir_reg[1] <= cfg_data;
                REG_DIR_Z:    dir_reg[2] <= cfg_data;
                REG_T_MIN:    tmin_reg   <= cfg_data;
                REG_T_MAX:    tmax_reg   <= cfg_data;
                default:      tmax_reg   <= tmax_reg;
            endcase
        end
    end

    logic signed [CW-1:0] v0 [3];
    logic signed [CW-1:0] v1 [3];
    logic signed [CW-1:0] v2 [3];

    assign v0[0] = s_first_vertex_x;
    assign v0[1] = s_first_vertex_y;
    assign v0[2] = s_first_vertex_z;
    assign v1[0] = s_second_vertex_x;
    assign v1[1] = s_second_vertex_y;
    assign v1[2] = s_second_vertex_z;
    assign v2[0] = s_third_vertex_x;
    assign v2[1] = s_third_vertex_y;
    assign v2[2] = s_third_vertex_z;

    logic out_valid_reg;
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    // Stage A: edges and origin offset
    logic                 va_reg;
    logic signed [EW-1:0] e1a_reg [3];
    logic signed [EW-1:0] e2a_reg [3];
    logic signed [EW-1:0] sa_reg  [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) va_reg <= 1'b0;
        else if (en)  va_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                e1a_reg[i] <= EW'(v1[i]) - EW'(v0[i]);
                e2a_reg[i] <= EW'(v2[i]) - EW'(v0[i]);
                sa_reg[i]  <= EW'(org_reg[i]) - EW'(v0[i]);
            end
        end
    end

    // Stage B: cross-product terms, order a1b2 a2b1 a2b0 a0b2 a0b1 a1b0
    logic                 vb_reg;
    logic signed [PW-1:0] pmb_reg [6];
    logic signed [PW-1:0] qmb_reg [6];
    logic signed [PW-1:0] cmb_reg [6];
    logic signed [EW-1:0] e1b_reg [3];
    logic signed [EW-1:0] e2b_reg [3];
    logic signed [EW-1:0] sb_reg  [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) vb_reg <= 1'b0;
        else if (en)  vb_reg <= va_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pmb_reg[0] <= PW'(dir_reg[1]) * PW'(e2a_reg[2]);
            pmb_reg[1] <= PW'(dir_reg[2]) * PW'(e2a_reg[1]);
            pmb_reg[2] <= PW'(dir_reg[2]) * PW'(e2a_reg[0]);
            pmb_reg[3] <= PW'(dir_reg[0]) * PW'(e2a_reg[2]);
            pmb_reg[4] <= PW'(dir_reg[0]) * PW'(e2a_reg[1]);
            pmb_reg[5] <= PW'(dir_reg[1]) * PW'(e2a_reg[0]);
            qmb_reg[0] <= PW'(sa_reg[1]) * PW'(e1a_reg[2]);
            qmb_reg[1] <= PW'(sa_reg[2]) * PW'(e1a_reg[1]);
            qmb_reg[2] <= PW'(sa_reg[2]) * PW'(e1a_reg[0]);
            qmb_reg[3] <= PW'(sa_reg[0]) * PW'(e1a_reg[2]);
            qmb_reg[4] <= PW'(sa_reg[0]) * PW'(e1a_reg[1]);
            qmb_reg[5] <= PW'(sa_reg[1]) * PW'(e1a_reg[0]);
            cmb_reg[0] <= PW'(e1a_reg[1]) * PW'(e2a_reg[2]);
            cmb_reg[1] <= PW'(e1a_reg[2]) * PW'(e2a_reg[1]);
            cmb_reg[2] <= PW'(e1a_reg[2]) * PW'(e2a_reg[0]);
            cmb_reg[3] <= PW'(e1a_reg[0]) * PW'(e2a_reg[2]);
            cmb_reg[4] <= PW'(e1a_reg[0]) * PW'(e2a_reg[1]);
            cmb_reg[5] <= PW'(e1a_reg[1]) * PW'(e2a_reg[0]);
            e1b_reg    <= e1a_reg;
            e2b_reg    <= e2a_reg;
            sb_reg     <= sa_reg;
        end
    end

    // Stage C: cross products p = d x e2, q = s x e1, c = e1 x e2
    logic                 vc_reg;
    logic signed [XW-1:0] pc_reg [3];
    logic signed [XW-1:0] qc_reg [3];
    logic signed [XW-1:0] cc_reg [3];
    logic signed [EW-1:0] e1c_reg [3];
    logic signed [EW-1:0] e2c_reg [3];
    logic signed [EW-1:0] sc_reg  [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) vc_reg <= 1'b0;
        else if (en)  vc_reg <= vb_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pc_reg[i] <= XW'(pmb_reg[2*i]) - XW'(pmb_reg[2*i+1]);
                qc_reg[i] <= XW'(qmb_reg[2*i]) - XW'(qmb_reg[2*i+1]);
                cc_reg[i] <= XW'(cmb_reg[2*i]) - XW'(cmb_reg[2*i+1]);
            end
            e1c_reg <= e1b_reg;
            e2c_reg <= e2b_reg;
            sc_reg  <= sb_reg;
        end
    end

    // Stage P: partial products on the halves of each cross product
    logic signed [LO_W:0]   plo_s [3];
    logic signed [HI_W-1:0] phi_s [3];
    logic signed [LO_W:0]   qlo_s [3];
    logic signed [HI_W-1:0] qhi_s [3];
    logic signed [LO_W:0]   clo_s [3];
    logic signed [HI_W-1:0] chi_s [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            plo_s[i] = $signed({1'b0, pc_reg[i][LO_W-1:0]});
            phi_s[i] = $signed(pc_reg[i][XW-1:LO_W]);
            qlo_s[i] = $signed({1'b0, qc_reg[i][LO_W-1:0]});
            qhi_s[i] = $signed(qc_reg[i][XW-1:LO_W]);
            clo_s[i] = $signed({1'b0, cc_reg[i][LO_W-1:0]});
            chi_s[i] = $signed(cc_reg[i][XW-1:LO_W]);
        end
    end

    logic                   vp_reg;
    logic signed [PL_W-1:0] dlo_reg [3];
    logic signed [PH_W-1:0] dhi_reg [3];
    logic signed [PL_W-1:0] ulo_reg [3];
    logic signed [PH_W-1:0] uhi_reg [3];
    logic signed [PL_W-1:0] vlo_reg [3];
    logic signed [PH_W-1:0] vhi_reg [3];
    logic signed [PL_W-1:0] tlo_reg [3];
    logic signed [PH_W-1:0] thi_reg [3];
    logic [QL_W-1:0]        sqll_reg [3];
    logic signed [QM_W-1:0] sqlh_reg [3];
    logic signed [QH_W-1:0] sqhh_reg [3];
    logic [2:0]             csignp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vp_reg <= 1'b0;
        else if (en)  vp_reg <= vc_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dlo_reg[i]    <= PL_W'(e1c_reg[i]) * PL_W'(plo_s[i]);
                dhi_reg[i]    <= PH_W'(e1c_reg[i]) * PH_W'(phi_s[i]);
                ulo_reg[i]    <= PL_W'(sc_reg[i]) * PL_W'(plo_s[i]);
                uhi_reg[i]    <= PH_W'(sc_reg[i]) * PH_W'(phi_s[i]);
                vlo_reg[i]    <= PL_W'(dir_reg[i]) * PL_W'(qlo_s[i]);
                vhi_reg[i]    <= PH_W'(dir_reg[i]) * PH_W'(qhi_s[i]);
                tlo_reg[i]    <= PL_W'(e2c_reg[i]) * PL_W'(qlo_s[i]);
                thi_reg[i]    <= PH_W'(e2c_reg[i]) * PH_W'(qhi_s[i]);
                sqll_reg[i]   <= QL_W'(clo_s[i]) * QL_W'(clo_s[i]);
                sqlh_reg[i]   <= QM_W'(chi_s[i]) * QM_W'(clo_s[i]);
                sqhh_reg[i]   <= QH_W'(chi_s[i]) * QH_W'(chi_s[i]);
                csignp_reg[i] <= cc_reg[i][XW-1];
            end
        end
    end

    // Stage D: dot-product terms, halves put back together
    logic                    vd_reg;
    logic signed [DW-1:0]    dmd_reg [3];
    logic signed [DW-1:0]    umd_reg [3];
    logic signed [DW-1:0]    vmd_reg [3];
    logic signed [DW-1:0]    tmd_reg [3];
    logic signed [CSQ_W-1:0] csqd_reg [3];
    logic [2:0]              csignd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vd_reg <= 1'b0;
        else if (en)  vd_reg <= vp_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dmd_reg[i]  <= (DW'(dhi_reg[i]) <<< LO_W) + DW'(dlo_reg[i]);
                umd_reg[i]  <= (DW'(uhi_reg[i]) <<< LO_W) + DW'(ulo_reg[i]);
                vmd_reg[i]  <= (DW'(vhi_reg[i]) <<< LO_W) + DW'(vlo_reg[i]);
                tmd_reg[i]  <= (DW'(thi_reg[i]) <<< LO_W) + DW'(tlo_reg[i]);
                csqd_reg[i] <= (CSQ_W'(sqhh_reg[i]) <<< (2 * LO_W))
                               + (CSQ_W'(sqlh_reg[i]) <<< (LO_W + 1))
                               + CSQ_W'(sqll_reg[i]);
            end
            csignd_reg <= csignp_reg;
        end
    end

    // Stage E: sums
    logic                 ve_reg;
    logic signed [DW-1:0] dete_reg;
    logic signed [DW-1:0] ue_reg;
    logic signed [DW-1:0] vve_reg;
    logic signed [DW-1:0] te_reg;
    logic [NB_W-1:0]      nrme_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) ve_reg <= 1'b0;
        else if (en)  ve_reg <= vd_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dete_reg <= dmd_reg[0] + dmd_reg[1] + dmd_reg[2];
            ue_reg   <= umd_reg[0] + umd_reg[1] + umd_reg[2];
            vve_reg  <= vmd_reg[0] + vmd_reg[1] + vmd_reg[2];
            te_reg   <= tmd_reg[0] + tmd_reg[1] + tmd_reg[2];
            nrme_reg <= {csignd_reg,
                         SS_W'(csqd_reg[0]) + SS_W'(csqd_reg[1]) + SS_W'(csqd_reg[2]),
                         csqd_reg[2], csqd_reg[1], csqd_reg[0]};
        end
    end

    // Stage F: fold the determinant sign into U and V, take |det| and |T| and the sign of t
    logic                 vf_reg;
    logic                 dnegf_reg;
    logic [DW-1:0]        adetf_reg;
    logic signed [DW-1:0] unf_reg;
    logic signed [DW-1:0] vnf_reg;
    logic [DW-1:0]        atf_reg;
    logic                 tnegf_reg;
    logic [NB_W-1:0]      nrmf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vf_reg <= 1'b0;
        else if (en)  vf_reg <= ve_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dnegf_reg <= dete_reg[DW-1];
            adetf_reg <= dete_reg[DW-1] ? -dete_reg : dete_reg;
            unf_reg   <= dete_reg[DW-1] ? -ue_reg : ue_reg;
            vnf_reg   <= dete_reg[DW-1] ? -vve_reg : vve_reg;
            atf_reg   <= te_reg[DW-1] ? -te_reg : te_reg;
            tnegf_reg <= te_reg[DW-1] ^ dete_reg[DW-1];
            nrmf_reg  <= nrme_reg;
        end
    end

    // Stage G: determinant and barycentric tests
    logic                   vg_reg;
    logic                   liveg_reg;
    logic                   dnegg_reg;
    logic [DW-1:0]          adetg_reg;
    logic [DW-1:0]          atg_reg;
    logic                   tnegg_reg;
    logic [NB_W-1:0]        nrmg_reg;
    logic signed [DW:0]     adet_s;
    logic signed [DW:0]     un_s;
    logic signed [DW:0]     uv_s;
    logic                   bad_g;

    assign adet_s = $signed({1'b0, adetf_reg});
    assign un_s   = (DW+1)'(unf_reg);
    assign uv_s   = un_s + (DW+1)'(vnf_reg);
    assign bad_g  = (adetf_reg < DET_MIN) || unf_reg[DW-1] || (un_s > adet_s)
                    || vnf_reg[DW-1] || (uv_s > adet_s);

    always_ff @(posedge aclk) begin
        if (!aresetn) vg_reg <= 1'b0;
        else if (en)  vg_reg <= vf_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            liveg_reg <= !bad_g;
            dnegg_reg <= dnegf_reg;
            adetg_reg <= adetf_reg;
            atg_reg   <= atf_reg;
            tnegg_reg <= tnegf_reg;
            nrmg_reg  <= nrmf_reg;
        end
    end

    // t magnitude = |T| * 2^FRAC_BITS / |det|
    logic            td_valid;
    logic [TQ_W-1:0] td_quo;
    logic            td_ovf;
    logic [TS_W-1:0] td_side;

    rti_div #(
        .NUM_W  (DW + FRAC_BITS),
        .DEN_W  (DW),
        .Q_W    (TQ_W),
        .SIDE_W (TS_W)
    ) u_t_div (
        .clk       (aclk),
        .rst_n     (aresetn),
        .en        (en),
        .in_valid  (vg_reg),
        .num       ({atg_reg, {FRAC_BITS{1'b0}}}),
        .den       (adetg_reg),
        .side_in   ({liveg_reg, dnegg_reg, tnegg_reg, nrmg_reg}),
        .out_valid (td_valid),
        .quo       (td_quo),
        .ovf       (td_ovf),
        .side_out  (td_side)
    );

    // Stage H: signed t
    logic                   vh_reg;
    logic                   liveh_reg;
    logic                   dnegh_reg;
    logic signed [CW+1:0]   th_reg;
    logic [NB_W-1:0]        nrmh_reg;
    logic signed [CW+1:0]   tq_s;

    assign tq_s = $signed({1'b0, td_quo});

    always_ff @(posedge aclk) begin
        if (!aresetn) vh_reg <= 1'b0;
        else if (en)  vh_reg <= td_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            liveh_reg <= td_side[TS_W-1] && !td_ovf;
            dnegh_reg <= td_side[TS_W-2];
            th_reg    <= td_side[TS_W-3] ? -tq_s : tq_s;
            nrmh_reg  <= td_side[NB_W-1:0];
        end
    end

    // Stage I: window test and t*d
    logic                   vi_reg;
    logic                   hiti_reg;
    logic                   dnegi_reg;
    logic signed [CW-1:0]   ti_reg;
    logic signed [2*CW-1:0] prodi_reg [3];
    logic [NB_W-1:0]        nrmi_reg;
    logic signed [CW-1:0]   th_cw;
    logic                   inwin;

    assign th_cw = th_reg[CW-1:0];
    assign inwin = (th_reg >= (CW+2)'(tmin_reg)) && (th_reg <= (CW+2)'(tmax_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) vi_reg <= 1'b0;
        else if (en)  vi_reg <= vh_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hiti_reg  <= liveh_reg && inwin;
            dnegi_reg <= dnegh_reg;
            ti_reg    <= th_cw;
            for (int i = 0; i < 3; i++) begin
                prodi_reg[i] <= (2*CW)'(th_cw) * (2*CW)'(dir_reg[i]);
            end
            nrmi_reg  <= nrmh_reg;
        end
    end

    // Stage J: hit point, floor then saturate
    logic                    vj_reg;
    logic                    hitj_reg;
    logic                    dnegj_reg;
    logic                    sszeroj_reg;
    logic signed [CW-1:0]    tj_reg;
    logic signed [CW-1:0]    hpj_reg [3];
    logic [CSQ_W-1:0]        csqj_reg [3];
    logic [SS_W-1:0]         ssj_reg;
    logic [2:0]              csignj_reg;
    logic signed [CW-1:0]    hp_next [3];
    logic [SS_W-1:0]         ss_i;

    assign ss_i = nrmi_reg[3*CSQ_W +: SS_W];

    always_comb begin
        logic signed [HW-1:0] acc;
        logic signed [HW-1:0] sh;
        for (int i = 0; i < 3; i++) begin
            acc = (HW'(org_reg[i]) <<< FRAC_BITS) + HW'(prodi_reg[i]);
            sh  = acc >>> FRAC_BITS;
            if (sh > HW'(C_MAX)) begin
                hp_next[i] = C_MAX;
            end else if (sh < HW'(C_MIN)) begin
                hp_next[i] = C_MIN;
            end else begin
                hp_next[i] = sh[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vj_reg <= 1'b0;
        else if (en)  vj_reg <= vi_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hitj_reg    <= hiti_reg;
            dnegj_reg   <= dnegi_reg;
            tj_reg      <= ti_reg;
            hpj_reg     <= hp_next;
            sszeroj_reg <= (ss_i == '0);
            ssj_reg     <= ss_i;
            csignj_reg  <= nrmi_reg[NB_W-1 -: 3];
            for (int i = 0; i < 3; i++) begin
                csqj_reg[i] <= nrmi_reg[i*CSQ_W +: CSQ_W];
            end
        end
    end

    // Normal: isqrt(c_i^2 * 2^60 / |c|^2) per axis
    logic            nd_valid [3];
    logic [NQ_W-1:0] nd_quo   [3];
    logic            nd_ovf   [3];
    logic [S0_W-1:0] nd_side0;
    logic            nd_side1;
    logic            nd_side2;

    rti_div #(
        .NUM_W (NN_W), .DEN_W (SS_W), .Q_W (NQ_W), .SIDE_W (S0_W)
    ) u_n_div0 (
        .clk (aclk), .rst_n (aresetn), .en (en), .in_valid (vj_reg),
        .num ({csqj_reg[0], {(2*NORM_FRAC){1'b0}}}), .den (ssj_reg),
        .side_in ({hitj_reg, tj_reg, hpj_reg[0], hpj_reg[1], hpj_reg[2],
                   dnegj_reg, sszeroj_reg, csignj_reg[0]}),
        .out_valid (nd_valid[0]), .quo (nd_quo[0]), .ovf (nd_ovf[0]),
        .side_out (nd_side0)
    );

    rti_div #(
        .NUM_W (NN_W), .DEN_W (SS_W), .Q_W (NQ_W), .SIDE_W (1)
    ) u_n_div1 (
        .clk (aclk), .rst_n (aresetn), .en (en), .in_valid (vj_reg),
        .num ({csqj_reg[1], {(2*NORM_FRAC){1'b0}}}), .den (ssj_reg),
        .side_in (csignj_reg[1]),
        .out_valid (nd_valid[1]), .quo (nd_quo[1]), .ovf (nd_ovf[1]),
        .side_out (nd_side1)
    );

    rti_div #(
        .NUM_W (NN_W), .DEN_W (SS_W), .Q_W (NQ_W), .SIDE_W (1)
    ) u_n_div2 (
        .clk (aclk), .rst_n (aresetn), .en (en), .in_valid (vj_reg),
        .num ({csqj_reg[2], {(2*NORM_FRAC){1'b0}}}), .den (ssj_reg),
        .side_in (csignj_reg[2]),
        .out_valid (nd_valid[2]), .quo (nd_quo[2]), .ovf (nd_ovf[2]),
        .side_out (nd_side2)
    );

    logic            sq_valid [3];
    logic [RB-1:0]   sq_root  [3];
    logic [S0_W:0]   sq_side0;
    logic [1:0]      sq_side1;
    logic [1:0]      sq_side2;

    rti_sqrt #(.X_W (NQ_W), .SIDE_W (S0_W + 1)) u_sqrt0 (
        .clk (aclk), .rst_n (aresetn), .en (en), .in_valid (nd_valid[0]),
        .x (nd_quo[0]), .side_in ({nd_side0, nd_ovf[0]}),
        .out_valid (sq_valid[0]), .root (sq_root[0]), .side_out (sq_side0)
    );

    rti_sqrt #(.X_W (NQ_W), .SIDE_W (2)) u_sqrt1 (
        .clk (aclk), .rst_n (aresetn), .en (en), .in_valid (nd_valid[1]),
        .x (nd_quo[1]), .side_in ({nd_side1, nd_ovf[1]}),
        .out_valid (sq_valid[1]), .root (sq_root[1]), .side_out (sq_side1)
    );

    rti_sqrt #(.X_W (NQ_W), .SIDE_W (2)) u_sqrt2 (
        .clk (aclk), .rst_n (aresetn), .en (en), .in_valid (nd_valid[2]),
        .x (nd_quo[2]), .side_in ({nd_side2, nd_ovf[2]}),
        .out_valid (sq_valid[2]), .root (sq_root[2]), .side_out (sq_side2)
    );

    // Output register
    logic                      hit_o;
    logic                      dneg_o;
    logic                      sszero_o;
    logic [2:0]                csign_o;
    logic [2:0]                novf_o;
    logic signed [NORM_W-1:0]  nrm_next [3];
    logic                      out_hit_reg;
    logic signed [CW-1:0]      out_t_reg;
    logic signed [CW-1:0]      out_hp_reg [3];
    logic signed [NORM_W-1:0]  out_n_reg  [3];

    assign hit_o      = sq_side0[S0_W];
    assign dneg_o     = sq_side0[3];
    assign sszero_o   = sq_side0[2];
    assign csign_o    = {sq_side2[1], sq_side1[1], sq_side0[1]};
    assign novf_o     = {sq_side2[0], sq_side1[0], sq_side0[0]};

    always_comb begin
        logic signed [NORM_W-1:0] mag;
        for (int i = 0; i < 3; i++) begin
            mag = NORM_W'(sq_root[i]);
            if (!hit_o || sszero_o || novf_o[i]) begin
                nrm_next[i] = '0;
            end else begin
                nrm_next[i] = (csign_o[i] != dneg_o) ? -mag : mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (en)  out_valid_reg <= sq_valid[0] && sq_valid[1] && sq_valid[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_hit_reg <= hit_o;
            out_t_reg   <= hit_o ? sq_side0[S0_W-1 -: CW] : '0;
            for (int i = 0; i < 3; i++) begin
                out_hp_reg[i] <= hit_o ? sq_side0[S0_W-1-CW*(i+1) -: CW] : '0;
            end
            out_n_reg   <= nrm_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_hit          = out_hit_reg;
    assign m_hit_distance = out_t_reg;
    assign m_hit_point_x  = out_hp_reg[0];
    assign m_hit_point_y  = out_hp_reg[1];
    assign m_hit_point_z  = out_hp_reg[2];
    assign m_normal_x     = out_n_reg[0];
    assign m_normal_y     = out_n_reg[1];
    assign m_normal_z     = out_n_reg[2];

`ifndef ASSERT_OFF
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_hit_distance == '0 && m_hit_point_x == '0
            && m_hit_point_y == '0 && m_hit_point_z == '0 && m_normal_x == '0
            && m_normal_y == '0 && m_normal_z == '0)
        else $error("miss word carries non-zero fields");

    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_hit_distance >= tmin_reg && m_hit_distance <= tmax_reg)
        else $error("hit distance outside window");

    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_x <= (NORM_W'(1) <<< NORM_FRAC)
            && m_normal_x >= -(NORM_W'(1) <<< NORM_FRAC)
            && m_normal_z <= (NORM_W'(1) <<< NORM_FRAC)
            && m_normal_z >= -(NORM_W'(1) <<< NORM_FRAC))
        else $error("normal component beyond unit length");

    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_valid[0] == sq_valid[1] && sq_valid[1] == sq_valid[2])
        else $error("normal lanes out of step");
`endif

endmodule
